// ----- sv/bfa_pkg.sv -----
// Shared types, sizes and codes of the bitmap frame allocator.
`default_nettype none
package bfa_pkg;

   localparam int MAX_FRAMES  = 4096;
   localparam int WORD_BITS   = 32;
   localparam int MAP_WORDS   = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
   localparam int BIT_IDX_W   = $clog2(WORD_BITS);
   localparam int REL_W       = $clog2(MAX_FRAMES);
   localparam int GROUP_SIZE  = 8;
   localparam int GROUP_COUNT = MAP_WORDS / GROUP_SIZE;
   localparam int GROUP_IDX_W = $clog2(GROUP_COUNT);
   localparam int GROUP_SEL_W = $clog2(GROUP_SIZE);

   localparam int FRAME_W = 20;
   localparam int COUNT_W = 13;
   localparam int MODE_W  = 2;
   localparam int STAT_W  = 2;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MARK    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

   localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_NO_FREE = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_OUTSIDE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_FRAME    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVE_FIRST = 8'd2;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [FRAME_W-1:0] frame_number;
      logic [COUNT_W-1:0] range_count;
   } req_payload_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_out;
      logic [STAT_W-1:0]  status;
   } rsp_payload_type;

endpackage
`default_nettype wire

// ----- sv/bitmap_frame_allocator_core.sv -----
// First-fit bitmap frame allocator: bitmap memory, full-word summary and sequencer.
`default_nettype none
//
//  Channel   Direction  Handshake             Contents
//  req_*     in         req_valid/req_stall   mode, frame_number, range_count
//  rsp_*     out        rsp_valid/rsp_stall   frame_out, status
//  csr_*     in         csr_valid/csr_ready   register index, write data
//
//  An allocate scans the full-word summary eight words per cycle, then reads
//  the chosen word, picks its lowest free bit and writes the word back. A
//  release checks the frame against the pool, then reads its word and writes
//  it back with the bit cleared; a mark range clips the run to the pool, then
//  costs one read and one write of the single-port bitmap memory per word.
//  Reset is synchronous; it and a clear empty the map at once through a valid
//  bit per word, so no clearing pass is needed. A stalled result waits in the
//  output register; the next transfer is taken as soon as the sequencer is idle.
//
module bitmap_frame_allocator_core (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  bfa_pkg::req_payload_type   req_payload,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output bfa_pkg::rsp_payload_type   rsp_payload,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire [bfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [bfa_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bfa_pkg::*;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SCAN  = 4'd1;
   localparam logic [3:0] ST_AREAD = 4'd2;
   localparam logic [3:0] ST_ABIT  = 4'd3;
   localparam logic [3:0] ST_AFIN  = 4'd4;
   localparam logic [3:0] ST_RCHK  = 4'd5;
   localparam logic [3:0] ST_RREAD = 4'd6;
   localparam logic [3:0] ST_RMOD  = 4'd7;
   localparam logic [3:0] ST_M1    = 4'd8;
   localparam logic [3:0] ST_M2    = 4'd9;
   localparam logic [3:0] ST_MREAD = 4'd10;
   localparam logic [3:0] ST_MMOD  = 4'd11;
   localparam logic [3:0] ST_DONE  = 4'd12;

   localparam logic [WORD_BITS-1:0] ALL_ONES   = {WORD_BITS{1'b1}};
   localparam logic [WORD_BITS-1:0] RESERVED_W = {{(WORD_BITS-1){1'b0}}, 1'b1};
   localparam logic [COUNT_W-1:0]   POOL_MAX   = COUNT_W'(MAX_FRAMES);

   // Configuration registers.
   logic [FRAME_W-1:0] base_frame_ff,    base_frame_in;
   logic [COUNT_W-1:0] frame_count_ff,   frame_count_in;
   logic               reserve_first_ff, reserve_first_in;

   // Map bookkeeping: a word that is not valid reads as the cleared pattern,
   // which holds the reserved bit in word 0 when the last clear reserved it.
   logic [MAP_WORDS-1:0] valid_ff, valid_in;
   logic [MAP_WORDS-1:0] full_ff,  full_in;
   logic                 clear_res_ff, clear_res_in;

   // Sequencer.
   logic [3:0]             state_ff, state_in;
   req_payload_type        op_ff, op_in;
   logic [GROUP_IDX_W-1:0] grp_ff, grp_in;
   logic [WORD_IDX_W-1:0]  cur_ff, cur_in;
   logic [WORD_IDX_W-1:0]  last_ff, last_in;
   logic [BIT_IDX_W-1:0]   bit_ff, bit_in;
   logic [BIT_IDX_W-1:0]   hi_bit_ff, hi_bit_in;
   logic                   first_ff, first_in;
   logic [WORD_BITS-1:0]   word_ff, word_in;
   logic [FRAME_W-1:0]     lo_ff, lo_in;
   logic [FRAME_W:0]       hi_ff, hi_in;
   logic [FRAME_W-1:0]     res_frame_ff, res_frame_in;
   logic [STAT_W-1:0]      res_status_ff, res_status_in;

   // Output register.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   // Bitmap memory, one read or write port used per cycle.
   logic [WORD_BITS-1:0]  map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic                  mem_rd_en;
   logic                  mem_we;
   logic [WORD_BITS-1:0]  mem_wr_data;

   // Combinational helpers.
   logic [COUNT_W-1:0]     pool_n;
   logic [WORD_BITS-1:0]   merged;
   logic [GROUP_SIZE-1:0]  grp_free;
   logic [GROUP_SEL_W-1:0] grp_pick;
   logic [BIT_IDX_W-1:0]   free_bit;
   logic [REL_W-1:0]       alloc_idx;
   logic [FRAME_W:0]       rel_diff;
   logic [FRAME_W:0]       range_end;
   logic [FRAME_W:0]       pool_end;
   logic [FRAME_W:0]       hi_m1_rel;
   logic [WORD_BITS-1:0]   lo_mask;
   logic [WORD_BITS-1:0]   hi_mask;
   logic                   can_load;

   // Relative word index and bit of the first marked frame.
   function automatic logic [WORD_IDX_W-1:0] rel_diff_lo(input logic [FRAME_W-1:0] lo,
                                                          input logic [FRAME_W-1:0] base);
      logic [FRAME_W-1:0] d;
      d = lo - base;
      return d[REL_W-1:BIT_IDX_W];
   endfunction

   function automatic logic [BIT_IDX_W-1:0] lo_bit(input logic [FRAME_W-1:0] lo,
                                                   input logic [FRAME_W-1:0] base);
      logic [FRAME_W-1:0] d;
      d = lo - base;
      return d[BIT_IDX_W-1:0];
   endfunction

   assign csr_ready   = 1'b1;
   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // Frame counts above the map size act as the map size.
   assign pool_n = (frame_count_ff > POOL_MAX) ? POOL_MAX : frame_count_ff;

   // The word just read, with the cleared pattern substituted when not valid.
   always_comb begin
      if (valid_ff[cur_ff]) begin
         merged = rd_data_ff;
      end else if ((cur_ff == '0) && clear_res_ff) begin
         merged = RESERVED_W;
      end else begin
         merged = '0;
      end
   end

   // Lowest word of the current scan group that still has a free bit.
   always_comb begin
      grp_free = ~full_ff[grp_ff*GROUP_SIZE +: GROUP_SIZE];
      grp_pick = '0;
      for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
         if (grp_free[i]) begin
            grp_pick = GROUP_SEL_W'(i);
         end
      end
   end

   // Lowest free bit of the word just read.
   always_comb begin
      free_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!merged[i]) begin
            free_bit = BIT_IDX_W'(i);
         end
      end
   end

   assign alloc_idx = {cur_ff, bit_ff};
   assign rel_diff  = {1'b0, op_ff.frame_number} - {1'b0, base_frame_ff};
   assign range_end = {1'b0, op_ff.frame_number} + (FRAME_W+1)'(op_ff.range_count);
   assign pool_end  = {1'b0, base_frame_ff} + (FRAME_W+1)'(pool_n);
   assign hi_m1_rel = hi_ff - {1'b0, base_frame_ff} - (FRAME_W+1)'(1);

   // Bits of the current word covered by the marked run.
   assign lo_mask = first_ff ? (ALL_ONES << bit_ff) : ALL_ONES;
   assign hi_mask = (cur_ff == last_ff) ?
                    (ALL_ONES >> (BIT_IDX_W'(WORD_BITS - 1) - hi_bit_ff)) : ALL_ONES;

   assign can_load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      base_frame_in    = base_frame_ff;
      frame_count_in   = frame_count_ff;
      reserve_first_in = reserve_first_ff;
      valid_in         = valid_ff;
      full_in          = full_ff;
      clear_res_in     = clear_res_ff;
      state_in         = state_ff;
      op_in            = op_ff;
      grp_in           = grp_ff;
      cur_in           = cur_ff;
      last_in          = last_ff;
      bit_in           = bit_ff;
      hi_bit_in        = hi_bit_ff;
      first_in         = first_ff;
      word_in          = word_ff;
      lo_in            = lo_ff;
      hi_in            = hi_ff;
      res_frame_in     = res_frame_ff;
      res_status_in    = res_status_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;
      mem_rd_en        = 1'b0;
      mem_we           = 1'b0;
      mem_wr_data      = merged;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BASE_FRAME:    base_frame_in    = csr_wdata[FRAME_W-1:0];
            CSR_FRAME_COUNT:   frame_count_in   = csr_wdata[COUNT_W-1:0];
            CSR_RESERVE_FIRST: reserve_first_in = csr_wdata[0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in         = req_payload;
               res_frame_in  = '0;
               res_status_in = STATUS_OK;
               grp_in        = '0;
               case (req_payload.mode)
                  MODE_ALLOC:   state_in = ST_SCAN;
                  MODE_RELEASE: state_in = ST_RCHK;
                  MODE_MARK:    state_in = ST_M1;
                  default: begin
                     // Clear: every word falls back to the cleared pattern.
                     valid_in     = '0;
                     full_in      = '0;
                     clear_res_in = reserve_first_ff;
                     state_in     = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (grp_free != '0) begin
               cur_in   = {grp_ff, grp_pick};
               state_in = ST_AREAD;
            end else if (grp_ff == GROUP_IDX_W'(GROUP_COUNT - 1)) begin
               res_status_in = STATUS_NO_FREE;
               state_in      = ST_DONE;
            end else begin
               grp_in = grp_ff + GROUP_IDX_W'(1);
            end
         end
         ST_AREAD: begin
            mem_rd_en = 1'b1;
            state_in  = ST_ABIT;
         end
         ST_ABIT: begin
            word_in  = merged;
            bit_in   = free_bit;
            state_in = ST_AFIN;
         end
         ST_AFIN: begin
            // Lower words are full, so a free bit past the pool means none left.
            if ({1'b0, alloc_idx} >= pool_n) begin
               res_status_in = STATUS_NO_FREE;
            end else begin
               mem_we          = 1'b1;
               mem_wr_data     = word_ff | (RESERVED_W << bit_ff);
               valid_in[cur_ff] = 1'b1;
               full_in[cur_ff]  = &(word_ff | (RESERVED_W << bit_ff));
               res_frame_in    = base_frame_ff + FRAME_W'(alloc_idx);
            end
            state_in = ST_DONE;
         end
         ST_RCHK: begin
            if (rel_diff[FRAME_W] || (rel_diff[FRAME_W-1:0] >= FRAME_W'(pool_n))) begin
               res_status_in = STATUS_OUTSIDE;
               state_in      = ST_DONE;
            end else begin
               cur_in   = rel_diff[REL_W-1:BIT_IDX_W];
               bit_in   = rel_diff[BIT_IDX_W-1:0];
               state_in = ST_RREAD;
            end
         end
         ST_RREAD: begin
            mem_rd_en = 1'b1;
            state_in  = ST_RMOD;
         end
         ST_RMOD: begin
            mem_we           = 1'b1;
            mem_wr_data      = merged & ~(RESERVED_W << bit_ff);
            valid_in[cur_ff] = 1'b1;
            full_in[cur_ff]  = 1'b0;
            state_in         = ST_DONE;
         end
         ST_M1: begin
            // Clip the run to the pool in absolute frame space.
            lo_in    = (op_ff.frame_number < base_frame_ff) ? base_frame_ff
                                                            : op_ff.frame_number;
            hi_in    = (range_end > pool_end) ? pool_end : range_end;
            state_in = ST_M2;
         end
         ST_M2: begin
            if ({1'b0, lo_ff} >= hi_ff) begin
               state_in = ST_DONE;
            end else begin
               cur_in    = rel_diff_lo(lo_ff, base_frame_ff);
               bit_in    = lo_bit(lo_ff, base_frame_ff);
               last_in   = hi_m1_rel[REL_W-1:BIT_IDX_W];
               hi_bit_in = hi_m1_rel[BIT_IDX_W-1:0];
               first_in  = 1'b1;
               state_in  = ST_MREAD;
            end
         end
         ST_MREAD: begin
            mem_rd_en = 1'b1;
            state_in  = ST_MMOD;
         end
         ST_MMOD: begin
            mem_we           = 1'b1;
            mem_wr_data      = merged | (lo_mask & hi_mask);
            valid_in[cur_ff] = 1'b1;
            full_in[cur_ff]  = &(merged | (lo_mask & hi_mask));
            first_in         = 1'b0;
            if (cur_ff == last_ff) begin
               state_in = ST_DONE;
            end else begin
               cur_in   = cur_ff + WORD_IDX_W'(1);
               state_in = ST_MREAD;
            end
         end
         ST_DONE: begin
            if (can_load) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.frame_out = res_frame_ff;
               rsp_data_in.status    = res_status_ff;
               state_in              = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[cur_ff] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= map_mem[cur_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_frame_ff    <= '0;
         frame_count_ff   <= POOL_MAX;
         reserve_first_ff <= 1'b1;
         valid_ff         <= '0;
         full_ff          <= '0;
         clear_res_ff     <= 1'b1;
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
      end else begin
         base_frame_ff    <= base_frame_in;
         frame_count_ff   <= frame_count_in;
         reserve_first_ff <= reserve_first_in;
         valid_ff         <= valid_in;
         full_ff          <= full_in;
         clear_res_ff     <= clear_res_in;
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      grp_ff        <= grp_in;
      cur_ff        <= cur_in;
      last_ff       <= last_in;
      bit_ff        <= bit_in;
      hi_bit_ff     <= hi_bit_in;
      first_ff      <= first_in;
      word_ff       <= word_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      res_frame_ff  <= res_frame_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule
`default_nettype wire

// ----- sv/bfa_checker.sv -----
// Port-level checks of the frame allocator, bound to its top level.
`default_nettype none
module bfa_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           req_valid,
   input wire                           req_stall,
   input wire                           rsp_valid,
   input wire                           rsp_stall,
   input bfa_pkg::rsp_payload_type      rsp_payload
);
   import bfa_pkg::*;

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // Only one item is worked on: an accepted transfer makes the block busy.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while an item is in work");

   // Failed answers carry frame zero and one of the two failure codes.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != STATUS_OK) |->
         (rsp_payload.frame_out == '0) &&
         ((rsp_payload.status == STATUS_NO_FREE) || (rsp_payload.status == STATUS_OUTSIDE)))
      else $error("bad failure result");

endmodule

bind bitmap_frame_allocator_core bfa_checker u_bfa_checker (.*);
`default_nettype wire

// ----- dv/tb_bitmap_frame_allocator_core.sv -----
// Self-checking testbench for the first-fit bitmap frame allocator core.
module tb_bitmap_frame_allocator_core;
   timeunit 1ns;
   timeprecision 1ps;

   import bfa_pkg::*;

   // The run ends with a failure once this many cycles have passed. The slowest
   // legal run (every item a full-pool mark range behind the longest gaps and
   // stalls) stays well below it.
   localparam int CYCLE_LIMIT = 2_000_000;
   // Cycles allowed after the last transfer for any stray result to show up.
   localparam int TAIL_CYCLES = 300;
   localparam int PHASE_ITEMS = 160;
   localparam int PHASE_COUNT = 8;
   // Register index that no register decodes; writes to it must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_TOP = 8'hFF;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bitmap_frame_allocator_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #10 clock = ~clock;

   // Shadow copy of the allocator: the pool registers and one used bit per
   // frame, indexed relative to the pool base. Bits above the current pool
   // size are kept, since a later, larger frame_count exposes them again.
   logic [FRAME_W-1:0] pool_base;
   logic [COUNT_W-1:0] pool_count;
   logic               reserve_bit0;
   bit                 frame_used [MAX_FRAMES];

   // Requests waiting to be offered, and the answers owed by the core in the
   // order their requests were accepted.
   req_payload_type    request_backlog [$];
   rsp_payload_type    frame_answers [$];

   int                 fail_count = 0;
   int                 cycles_run = 0;
   int                 gap_left = 0;
   int                 stall_left = 0;
   // Set for the final phase so that the run ends with back-to-back traffic.
   bit                 bursts_off = 1'b0;

   function automatic void wipe_map();
      foreach (frame_used[i])
         frame_used[i] = 1'b0;
      frame_used[0] = reserve_bit0;
   endfunction

   // Frames the pool really holds: frame_count saturates at the map size.
   function automatic int unsigned live_frames();
      return (pool_count > MAX_FRAMES) ? MAX_FRAMES : pool_count;
   endfunction

   // Applies one accepted request to the shadow map and returns the answer
   // the core must give for it.
   function automatic rsp_payload_type serve_frame_request(req_payload_type item);
      rsp_payload_type answer;
      int unsigned     live;
      int unsigned     rel;
      int unsigned     slot;
      int unsigned     lo;
      int unsigned     hi;
      int unsigned     plo;
      int unsigned     phi;
      bit              found;
      answer.frame_out = '0;
      answer.status = STATUS_OK;
      live = live_frames();
      plo = pool_base;
      found = 1'b0;
      slot = 0;
      case (item.mode)
         MODE_ALLOC: begin
            // First fit from the bottom of the pool; the absolute number wraps
            // at the 20-bit frame space.
            for (rel = 0; rel < live && !found; rel++) begin
               if (!frame_used[rel]) begin
                  found = 1'b1;
                  slot = rel;
               end
            end
            if (found) begin
               frame_used[slot] = 1'b1;
               answer.frame_out = pool_base + slot[FRAME_W-1:0];
            end else begin
               answer.status = STATUS_NO_FREE;
            end
         end
         MODE_RELEASE: begin
            lo = item.frame_number;
            if (lo < plo || lo - plo >= live)
               answer.status = STATUS_OUTSIDE;
            else
               frame_used[lo - plo] = 1'b0;
         end
         MODE_MARK: begin
            // Clip the run to the pool in 32-bit space so that nothing wraps.
            lo = item.frame_number;
            hi = lo + item.range_count;
            phi = plo + live;
            if (lo < plo)
               lo = plo;
            if (hi > phi)
               hi = phi;
            for (rel = lo; rel < hi; rel++)
               frame_used[rel - plo] = 1'b1;
         end
         default: begin
            wipe_map();
         end
      endcase
      return answer;
   endfunction

   // Offset into the pool, biased toward the low frames where first fit
   // keeps most of the used bits.
   function automatic int unsigned pool_offset(int unsigned live);
      if ($urandom_range(0, 1) == 0)
         return $urandom_range(0, ((live > 64) ? 64 : live) - 1);
      return $urandom_range(0, live - 1);
   endfunction

   // Mostly well-formed requests aimed at the current pool, with a share of
   // releases and marks anywhere in the frame space and some pure noise.
   // Fields a mode ignores are still random so that every bit toggles.
   function automatic req_payload_type random_request();
      req_payload_type item;
      int unsigned     live;
      int unsigned     pick;
      live = live_frames();
      item.mode = MODE_ALLOC;
      item.frame_number = FRAME_W'($urandom);
      item.range_count = COUNT_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         item.mode = MODE_ALLOC;
      end else if (pick < 75) begin
         item.mode = MODE_RELEASE;
         if (live != 0 && $urandom_range(0, 6) != 0)
            item.frame_number = pool_base + FRAME_W'(pool_offset(live));
      end else if (pick < 92) begin
         item.mode = MODE_MARK;
         if (live != 0 && $urandom_range(0, 5) != 0)
            item.frame_number = pool_base + FRAME_W'(pool_offset(live))
                                - FRAME_W'($urandom_range(0, 3));
         pick = $urandom_range(0, 99);
         if (pick < 80)
            item.range_count = COUNT_W'($urandom_range(0, 40));
         else if (pick < 95)
            item.range_count = COUNT_W'($urandom_range(0, live + 8));
      end else if (pick < 95) begin
         item.mode = MODE_CLEAR;
      end else begin
         item.mode = MODE_W'($urandom);
      end
      return item;
   endfunction

   task automatic queue_request(input logic [MODE_W-1:0] mode,
                                input logic [FRAME_W-1:0] frame_number,
                                input logic [COUNT_W-1:0] range_count);
      req_payload_type item;
      item.mode = mode;
      item.frame_number = frame_number;
      item.range_count = range_count;
      request_backlog.push_back(item);
   endtask

   // Returns at a rising edge once nothing is waiting to be sent, nothing is
   // on the request channel and every owed answer has arrived. The test is
   // made at the falling edge, when all updates of the rising edge have
   // settled. The core produces one answer per request, so it is idle then.
   task automatic wait_for_quiet();
      do
         @(negedge clock);
      while (request_backlog.size() != 0 || req_valid || frame_answers.size() != 0);
      @(posedge clock);
   endtask

   // Writes all three pool registers and one index that decodes to nothing.
   // Valid stays high from one write to the next and drops after the last, so
   // it gets a single nonblocking update per time step. Only the low bits of
   // each data word may take effect.
   task automatic program_pool(input logic [CSR_DATA_W-1:0] base_word,
                               input logic [CSR_DATA_W-1:0] count_word,
                               input logic [CSR_DATA_W-1:0] reserve_word,
                               input logic [CSR_IDX_W-1:0]  stray_index);
      logic [CSR_IDX_W-1:0]  idx [4];
      logic [CSR_DATA_W-1:0] word [4];
      int                    n;
      idx = '{CSR_BASE_FRAME, CSR_FRAME_COUNT, stray_index, CSR_RESERVE_FIRST};
      word = '{base_word, count_word, CSR_DATA_W'($urandom), reserve_word};
      for (n = 0; n < 4; n++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[n];
         csr_wdata <= word[n];
         do
            @(posedge clock);
         while (!csr_ready);
         case (idx[n])
            CSR_BASE_FRAME:    pool_base = word[n][FRAME_W-1:0];
            CSR_FRAME_COUNT:   pool_count = word[n][COUNT_W-1:0];
            CSR_RESERVE_FIRST: reserve_bit0 = word[n][0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // Request driver. A transfer at this edge is predicted at once, while the
   // pool registers are known to be stable. A stalled request is held as is;
   // otherwise the next one is offered unless an idle burst is running.
   always @(posedge clock) begin : request_driver
      logic moved;
      moved = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (moved)
            frame_answers.push_back(serve_frame_request(req_payload));
         if (req_valid && !moved) begin
            // Stalled: payload and valid stay put.
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (request_backlog.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!bursts_off && $urandom_range(0, 5) == 0) begin
            // This cycle is idle too, as the first of the burst.
            gap_left = $urandom_range(0, 5);
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_payload <= request_backlog.pop_front();
         end
      end
   end

   // Answer monitor. Each answer transfer is checked against the oldest owed
   // answer; stall bursts are thrown in on the way.
   always @(posedge clock) begin : answer_monitor
      rsp_payload_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_answers.size() == 0) begin
               $error("answer transfer with none owed: frame_out %h, status %0d",
                      rsp_payload.frame_out, rsp_payload.status);
               fail_count++;
            end else begin
               want = frame_answers.pop_front();
               if (rsp_payload.frame_out !== want.frame_out) begin
                  $error("frame_out: expected %h, actual %h",
                         want.frame_out, rsp_payload.frame_out);
                  fail_count++;
               end
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0d, actual %0d",
                         want.status, rsp_payload.status);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!bursts_off && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock)
      cycles_run <= cycles_run + 1;

   // A hung handshake or a lost answer ends here.
   initial begin : watchdog
      wait (cycles_run >= CYCLE_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int                 phase;
      int                 k;
      logic [FRAME_W-1:0] base_pick;
      logic [COUNT_W-1:0] count_pick;
      logic               reserve_pick;

      // Register and map state the core comes out of reset with.
      pool_base = '0;
      pool_count = COUNT_W'(MAX_FRAMES);
      reserve_bit0 = 1'b1;
      wipe_map();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset pool: frame 0 reserved, 4096 frames at base 0. The reserved
      // frame is released and handed out again; releases just inside, just
      // past and far past the pool; an empty mark, a mark clipped at the top
      // of the pool and one entirely outside with both fields at their
      // maximum.
      queue_request(MODE_ALLOC, '0, '0);
      queue_request(MODE_ALLOC, '1, '1);
      queue_request(MODE_RELEASE, 20'd0, '0);
      queue_request(MODE_ALLOC, '0, '0);
      queue_request(MODE_RELEASE, 20'd4095, '0);
      queue_request(MODE_RELEASE, 20'd4096, '0);
      queue_request(MODE_RELEASE, '1, '1);
      queue_request(MODE_MARK, 20'd0, 13'd0);
      queue_request(MODE_MARK, 20'd100, 13'd4096);
      queue_request(MODE_MARK, '1, '1);
      queue_request(MODE_ALLOC, '0, '0);
      queue_request(MODE_CLEAR, '0, '0);
      wait_for_quiet();

      // Three-frame pool with no reserved frame: fill it, then one more
      // allocate must find the pool full.
      program_pool(32'hFFF1_2345, 32'hFFFF_E003, 32'hFFFF_FFFE, CSR_UNUSED_TOP);
      queue_request(MODE_CLEAR, '0, '0);
      repeat (4) queue_request(MODE_ALLOC, '0, '0);
      wait_for_quiet();

      // Empty pool: allocate finds nothing, any release is outside.
      program_pool(32'h0001_2345, 32'h0000_0000, 32'h0000_0001, 8'h03);
      queue_request(MODE_ALLOC, '0, '0);
      queue_request(MODE_RELEASE, 20'h12345, '0);
      wait_for_quiet();

      // Pool straddling the top of the frame space: the second allocate
      // wraps to frame 0, which a release then sees as below the base. A
      // mark starting under the base fills the rest, so the pool ends full.
      program_pool(32'h000F_FFFE, 32'h0000_0008, 32'h0000_0001, 8'h80);
      queue_request(MODE_CLEAR, '0, '0);
      queue_request(MODE_ALLOC, '0, '0);
      queue_request(MODE_ALLOC, '0, '0);
      queue_request(MODE_RELEASE, 20'd0, '0);
      queue_request(MODE_MARK, 20'hFFFFD, 13'd10);
      queue_request(MODE_ALLOC, '0, '0);

      // Random phases, each under its own pool setting. Every phase starts
      // once the core has drained, which also exercises a sender that waits
      // for every answer before going on.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         base_pick = FRAME_W'($urandom);
         count_pick = COUNT_W'($urandom_range(1, 200));
         reserve_pick = 1'($urandom);
         case (phase)
            0: begin
               base_pick = '0;
               count_pick = COUNT_W'(MAX_FRAMES);
               reserve_pick = 1'b1;
            end
            1: begin
               count_pick = COUNT_W'($urandom_range(1, 64));
               reserve_pick = 1'b0;
            end
            2: begin
               base_pick = '1;
               count_pick = COUNT_W'(MAX_FRAMES);
            end
            3: count_pick = '1;
            4: count_pick = '0;
            5: count_pick = COUNT_W'($urandom_range(1, 16));
            6: begin
               base_pick = 20'hFFFFF - FRAME_W'($urandom_range(0, 40));
               count_pick = COUNT_W'($urandom_range(8, 64));
            end
            default: ;
         endcase
         wait_for_quiet();
         program_pool({12'($urandom), base_pick}, {19'($urandom), count_pick},
                      {31'($urandom), reserve_pick}, CSR_IDX_W'($urandom_range(3, 255)));
         if (phase == PHASE_COUNT - 1)
            bursts_off = 1'b1;
         if ($urandom_range(0, 1) == 0)
            queue_request(MODE_CLEAR, FRAME_W'($urandom), COUNT_W'($urandom));
         for (k = 0; k < PHASE_ITEMS; k++)
            request_backlog.push_back(random_request());
      end

      wait_for_quiet();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && frame_answers.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- files.f -----
sv/bfa_pkg.sv
sv/bitmap_frame_allocator_core.sv
sv/bfa_checker.sv
dv/tb_bitmap_frame_allocator_core.sv
